// ===== rtl/rv32im_alu_pkg.sv =====
// Package for the RV32IM execute ALU: operation classes, function codes and
// the pipeline lane record. No dependencies.
`default_nettype none
package rv32im_alu_pkg;

    localparam int XLEN      = 32;
    localparam int DIV_STEPS = XLEN;

    localparam logic [2:0] OP_ADDR   = 3'd0;
    localparam logic [2:0] OP_LUI    = 3'd1;
    localparam logic [2:0] OP_AUIPC  = 3'd2;
    localparam logic [2:0] OP_BRANCH = 3'd3;
    localparam logic [2:0] OP_REG    = 3'd4;
    localparam logic [2:0] OP_IMM    = 3'd5;
    localparam logic [2:0] OP_MULDIV = 3'd6;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // funct3 of the shift groups in the ALU classes
    localparam logic [2:0] F3_SHL = 3'd1;
    localparam logic [2:0] F3_SHR = 3'd5;

    localparam logic [3:0] FN_ADD  = 4'd0;
    localparam logic [3:0] FN_SUB  = 4'd1;
    localparam logic [3:0] FN_SLL  = 4'd2;
    localparam logic [3:0] FN_SLT  = 4'd4;
    localparam logic [3:0] FN_SLTU = 4'd6;
    localparam logic [3:0] FN_XOR  = 4'd8;
    localparam logic [3:0] FN_SRL  = 4'd10;
    localparam logic [3:0] FN_SRA  = 4'd11;
    localparam logic [3:0] FN_OR   = 4'd12;
    localparam logic [3:0] FN_AND  = 4'd14;

    localparam logic [2:0] F3_MUL    = 3'd0;
    localparam logic [2:0] F3_MULH   = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_MULHU  = 3'd3;
    localparam logic [2:0] F3_DIV    = 3'd4;
    localparam logic [2:0] F3_DIVU   = 3'd5;
    localparam logic [2:0] F3_REM    = 3'd6;
    localparam logic [2:0] F3_REMU   = 3'd7;

    localparam logic [XLEN-1:0] PC_STEP = 32'd4;

    // One transaction as it travels down the pipeline
    typedef struct packed {
        logic            valid;
        logic            is_div;
        logic            is_mul;
        logic            mul_hi;
        logic            rem_sel;
        logic            neg_q;
        logic            neg_r;
        logic            b_zero;
        logic            illegal;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] corr;
        logic [XLEN-1:0] res;
    } t_lane;

endpackage
`default_nettype wire

// ===== rtl/rv32im_execute_alu.sv =====
// RV32IM execute ALU: deep pipeline with a one-bit-per-stage divider.
// Depends on rv32im_alu_pkg.
`default_nettype none
// Usage:
//   Drive start high with operation, funct, operand_a and operand_b; the
//   transaction is taken at that edge. busy is always low, so a new
//   transaction may be issued in every cycle.
//   Each result appears on o_result and o_illegal for exactly one cycle,
//   marked by o_valid, after it has passed the input register, the lane stages and the output register.
//   Results leave in issue order; the receiver cannot stall the block.
// Pipeline and throughput:
//   One input register, then 33 lane stages, of which 32 each run one
//   restoring divide step (one 33-bit compare and subtract), then the
//   output register. All classes take the same path length, set by the
//   divider chain. Multiplies use four 16x16 partial products at the first
//   lane stage and sum them at the second. Throughput is one per cycle.
// Reset:
//   A synchronous low i_rst_n clears all valid bits; transactions in
//   flight are dropped and no result is strobed until new ones arrive.
module rv32im_execute_alu
    import rv32im_alu_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic [2:0]      i_operation,
    input  wire logic [3:0]      i_funct,
    input  wire logic [XLEN-1:0] i_operand_a,
    input  wire logic [XLEN-1:0] i_operand_b,
    output logic                 o_valid,
    output logic [XLEN-1:0]      o_result,
    output logic                 o_illegal
);

    localparam int HALF = XLEN / 2;

    // Input register
    logic            r_s1_valid;
    logic [2:0]      r_s1_op;
    logic [3:0]      r_s1_fn;
    logic [XLEN-1:0] r_s1_a;
    logic [XLEN-1:0] r_s1_b;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        r_s1_op <= i_operation;
        r_s1_fn <= i_funct;
        r_s1_a  <= i_operand_a;
        r_s1_b  <= i_operand_b;
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
        end
    end

    // Decode and simple ALU on the input register
    logic [2:0]      s1_f3;
    logic [4:0]      s1_sh;
    logic            s1_slt;
    logic            s1_sltu;
    logic            s1_take;
    logic [XLEN-1:0] s1_sum;
    logic [XLEN-1:0] s1_abs_a;
    logic [XLEN-1:0] s1_abs_b;
    logic            s1_sdiv;
    t_lane           n_lane0;

    assign s1_f3   = r_s1_fn[3:1];
    assign s1_sh   = r_s1_b[4:0];
    assign s1_sum  = r_s1_a + r_s1_b;
    assign s1_slt  = $signed(r_s1_a) < $signed(r_s1_b);
    assign s1_sltu = r_s1_a < r_s1_b;
    assign s1_sdiv = !s1_f3[0];
    assign s1_abs_a = (s1_sdiv && r_s1_a[XLEN-1]) ? (~r_s1_a + 1'b1) : r_s1_a;
    assign s1_abs_b = (s1_sdiv && r_s1_b[XLEN-1]) ? (~r_s1_b + 1'b1) : r_s1_b;

    always_comb begin
        n_lane0         = '0;
        n_lane0.valid   = r_s1_valid;
        n_lane0.a       = r_s1_a;
        n_lane0.b_zero  = (r_s1_b == '0);
        n_lane0.rem_sel = s1_f3[1];
        n_lane0.neg_q   = s1_sdiv && (r_s1_a[XLEN-1] ^ r_s1_b[XLEN-1]);
        n_lane0.neg_r   = s1_sdiv && r_s1_a[XLEN-1];
        n_lane0.mul_hi  = (s1_f3 != F3_MUL);
        s1_take         = 1'b0;
        // high-word sign corrections for the unsigned partial products
        n_lane0.corr    = ((s1_f3 == F3_MULH || s1_f3 == F3_MULHSU) && r_s1_a[XLEN-1]
                           ? r_s1_b : '0)
                        + ((s1_f3 == F3_MULH) && r_s1_b[XLEN-1] ? r_s1_a : '0);
        case (r_s1_op)
            OP_ADDR, OP_AUIPC: n_lane0.res = s1_sum;
            OP_LUI:            n_lane0.res = r_s1_b;
            OP_BRANCH: begin
                case (s1_f3)
                    F3_BEQ:  s1_take = (r_s1_a == r_s1_b);
                    F3_BNE:  s1_take = (r_s1_a != r_s1_b);
                    F3_BLT:  s1_take = s1_slt;
                    F3_BGE:  s1_take = !s1_slt;
                    F3_BLTU: s1_take = s1_sltu;
                    F3_BGEU: s1_take = !s1_sltu;
                    default: n_lane0.illegal = 1'b1;
                endcase
                if (!n_lane0.illegal) begin
                    n_lane0.res = s1_take ? s1_sum : r_s1_a + PC_STEP;
                end
            end
            OP_REG, OP_IMM: begin
                // immediate forms ignore bit 0 except on shifts
                case ((r_s1_op == OP_IMM && s1_f3 != F3_SHL && s1_f3 != F3_SHR)
                      ? {s1_f3, 1'b0} : r_s1_fn)
                    FN_ADD:  n_lane0.res = s1_sum;
                    FN_SUB:  n_lane0.res = r_s1_a - r_s1_b;
                    FN_SLL:  n_lane0.res = r_s1_a << s1_sh;
                    FN_SLT:  n_lane0.res = {{(XLEN-1){1'b0}}, s1_slt};
                    FN_SLTU: n_lane0.res = {{(XLEN-1){1'b0}}, s1_sltu};
                    FN_XOR:  n_lane0.res = r_s1_a ^ r_s1_b;
                    FN_SRL:  n_lane0.res = r_s1_a >> s1_sh;
                    FN_SRA:  n_lane0.res = $unsigned($signed(r_s1_a) >>> s1_sh);
                    FN_OR:   n_lane0.res = r_s1_a | r_s1_b;
                    FN_AND:  n_lane0.res = r_s1_a & r_s1_b;
                    default: n_lane0.illegal = 1'b1;
                endcase
            end
            OP_MULDIV: begin
                n_lane0.is_div = s1_f3[2];
                n_lane0.is_mul = !s1_f3[2];
            end
            default: n_lane0.illegal = 1'b1;
        endcase
    end

    // Multiplier partial products, registered alongside lane stage 0
    logic [XLEN-1:0] r_pp_ll, r_pp_lh, r_pp_hl, r_pp_hh;

    always_ff @(posedge i_clk) begin
        r_pp_ll <= r_s1_a[HALF-1:0]    * r_s1_b[HALF-1:0];
        r_pp_lh <= r_s1_a[HALF-1:0]    * r_s1_b[XLEN-1:HALF];
        r_pp_hl <= r_s1_a[XLEN-1:HALF] * r_s1_b[HALF-1:0];
        r_pp_hh <= r_s1_a[XLEN-1:HALF] * r_s1_b[XLEN-1:HALF];
    end

    // Lane pipeline; stage 1 folds in the product
    t_lane           r_lane [DIV_STEPS+1];
    t_lane           n_lane1;
    logic [2*XLEN-1:0] mul_full;

    assign mul_full = {r_pp_hh, r_pp_ll}
                    + {{HALF{1'b0}}, r_pp_lh, {HALF{1'b0}}}
                    + {{HALF{1'b0}}, r_pp_hl, {HALF{1'b0}}};

    always_comb begin
        n_lane1 = r_lane[0];
        if (r_lane[0].is_mul) begin
            n_lane1.res = r_lane[0].mul_hi ? (mul_full[2*XLEN-1:XLEN] - r_lane[0].corr)
                                           : mul_full[XLEN-1:0];
        end
    end

    // Advance the lanes; reset empties them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_lane[k] <= '0;
            end
        end else begin
            r_lane[0] <= n_lane0;
            r_lane[1] <= n_lane1;
            for (int k = 2; k <= DIV_STEPS; k++) begin
                r_lane[k] <= r_lane[k-1];
            end
        end
    end

    // Divider chain: one restoring step per stage
    logic [XLEN-1:0] r_rem [DIV_STEPS+1];
    logic [XLEN-1:0] r_quo [DIV_STEPS+1];
    logic [XLEN-1:0] r_dvs [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_quo[0] <= s1_abs_a;
        r_dvs[0] <= s1_abs_b;
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        logic [XLEN:0] trial;
        logic [XLEN:0] diff;

        assign trial = {r_rem[k-1], r_quo[k-1][XLEN-1]};
        assign diff  = trial - {1'b0, r_dvs[k-1]};

        always_ff @(posedge i_clk) begin
            r_dvs[k] <= r_dvs[k-1];
            if (!diff[XLEN]) begin
                r_rem[k] <= diff[XLEN-1:0];
                r_quo[k] <= {r_quo[k-1][XLEN-2:0], 1'b1};
            end else begin
                r_rem[k] <= trial[XLEN-1:0];
                r_quo[k] <= {r_quo[k-1][XLEN-2:0], 1'b0};
            end
        end
    end

    // Final select: divide signs and zero divisor
    t_lane           last;
    logic [XLEN-1:0] div_res;

    assign last = r_lane[DIV_STEPS];

    always_comb begin
        if (last.rem_sel) begin
            if (last.b_zero) begin
                div_res = last.a;
            end else begin
                div_res = last.neg_r ? (~r_rem[DIV_STEPS] + 1'b1) : r_rem[DIV_STEPS];
            end
        end else begin
            if (last.b_zero) begin
                div_res = '1;
            end else begin
                div_res = last.neg_q ? (~r_quo[DIV_STEPS] + 1'b1) : r_quo[DIV_STEPS];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        o_result <= last.is_div ? div_res : last.res;
        if (!i_rst_n) begin
            o_valid   <= 1'b0;
            o_illegal <= 1'b0;
        end else begin
            o_valid   <= last.valid;
            o_illegal <= last.valid && last.illegal;
        end
    end

    a_illegal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_illegal |-> (o_result == '0))
        else $error("illegal result is not zero");

    a_illegal_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_illegal |-> o_valid)
        else $error("illegal flag without strobe");

    a_class_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_lane[0].is_div && r_lane[0].is_mul))
        else $error("transaction marked both multiply and divide");

    a_strobe_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_valid == $past(last.valid)))
        else $error("strobe lost or invented at the output");

endmodule
`default_nettype wire
